// ===== rtl/core/ssrd_pkg.sv =====
// Shared types, register map and quarter-sine helpers for the sine-ramp dimmer.
`default_nettype none

package ssrd_pkg;

    // Default ramp phase resolution in bits.
    localparam int FRACTION_BITS_DEF = 10;

    // Widths of the time values in seconds.
    localparam int TIME_W = 17;
    localparam int RAMP_W = 16;

    // APB register map, word index taken from paddr[4:2].
    localparam int          ADDR_W        = 5;
    localparam logic [2:0]  REG_ON_WD     = 3'd0;
    localparam logic [2:0]  REG_OFF_WD    = 3'd1;
    localparam logic [2:0]  REG_ON_WE     = 3'd2;
    localparam logic [2:0]  REG_OFF_WE    = 3'd3;
    localparam logic [2:0]  REG_RAMP      = 3'd4;

    // Reset values of the schedule, in minutes.
    localparam logic [10:0] ON_WD_RST     = 11'd480;
    localparam logic [10:0] OFF_WD_RST    = 11'd1320;
    localparam logic [10:0] ON_WE_RST     = 11'd600;
    localparam logic [10:0] OFF_WE_RST    = 11'd1440;
    localparam logic [9:0]  RAMP_RST      = 10'd30;

    // Weekday codes that select the weekend schedule.
    localparam logic [2:0]  DAY_SUN       = 3'd0;
    localparam logic [2:0]  DAY_FRI       = 3'd5;
    localparam logic [2:0]  DAY_SAT       = 3'd6;

    localparam logic [7:0]  LEVEL_FULL    = 8'd255;
    localparam logic [7:0]  LEVEL_OFF     = 8'd0;

    // pi/2 in unsigned Q2.62.
    localparam logic [63:0] Q62_PI_HALF   = 64'h6487_ED51_10B4_611A;

    typedef struct packed {
        logic [10:0] on_wd;
        logic [10:0] off_wd;
        logic [10:0] on_we;
        logic [10:0] off_we;
        logic [9:0]  ramp;
    } cfg_t;

    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_FULL,
        LVL_RAMP
    } level_mode_t;

    typedef struct packed {
        logic        valid;
        level_mode_t mode;
    } cell_ctrl_t;

    // (a*b) >> 62 for Q2.62 operands below 2.0.
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor(255 * sin(pi/2 * k / 2^fbits)), odd Taylor series to x^23, truncated products.
    function automatic logic [7:0] quarter_sine(input logic [31:0] k, input int fbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        logic [63:0] kk;
        kk = {32'd0, k};
        if (kk == 64'd0) begin
            return LEVEL_OFF;
        end
        if (kk >= (64'd1 << fbits)) begin
            return LEVEL_FULL;
        end
        x    = q62_mul(Q62_PI_HALF, kk << (62 - fbits));
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (int i = 1; i <= 11; i++) begin
            term = q62_mul(term, x2) / 64'((2 * i) * (2 * i + 1));
            if ((i % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        scaled = (sum >> 8) * 64'd255;
        return scaled[61:54];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssrd_regs.sv =====
// APB register file holding the on/off schedule and the ramp length.
`default_nettype none

module ssrd_regs
    import ssrd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready,
    output      cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_wd  <= ON_WD_RST;
            cfg_reg.off_wd <= OFF_WD_RST;
            cfg_reg.on_we  <= ON_WE_RST;
            cfg_reg.off_we <= OFF_WE_RST;
            cfg_reg.ramp   <= RAMP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ON_WD:  cfg_reg.on_wd  <= pwdata[10:0];
                REG_OFF_WD: cfg_reg.off_wd <= pwdata[10:0];
                REG_ON_WE:  cfg_reg.on_we  <= pwdata[10:0];
                REG_OFF_WE: cfg_reg.off_we <= pwdata[10:0];
                REG_RAMP:   cfg_reg.ramp   <= pwdata[9:0];
                default: ;  // drop writes past the map
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ON_WD:  prdata = {21'd0, cfg_reg.on_wd};
            REG_OFF_WD: prdata = {21'd0, cfg_reg.off_wd};
            REG_ON_WE:  prdata = {21'd0, cfg_reg.on_we};
            REG_OFF_WE: prdata = {21'd0, cfg_reg.off_we};
            REG_RAMP:   prdata = {22'd0, cfg_reg.ramp};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssrd_cell.sv =====
// One restoring-division cell: settles one quotient bit and hands on the remainder.
`default_nettype none

module ssrd_cell
    import ssrd_pkg::*;
#(
    parameter int QW = FRACTION_BITS_DEF + 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire cell_ctrl_t        ctrl_in,
    input  wire logic [RAMP_W:0]   rem_in,
    input  wire logic [RAMP_W-1:0] div_in,
    input  wire logic [QW-1:0]     quo_in,
    output      cell_ctrl_t        ctrl_out,
    output      logic [RAMP_W-1:0] rem_out,
    output      logic [RAMP_W-1:0] div_out,
    output      logic [QW-1:0]     quo_out
);

    cell_ctrl_t        ctrl_reg;
    logic [RAMP_W-1:0] rem_reg;
    logic [RAMP_W-1:0] rem_next;
    logic [RAMP_W-1:0] div_reg;
    logic [QW-1:0]     quo_reg;
    logic [RAMP_W:0]   diff;
    logic              ge;

    // Subtract the divisor when it fits; the remainder then stays below it.
    assign ge       = rem_in >= {1'b0, div_in};
    assign diff     = rem_in - {1'b0, div_in};
    assign rem_next = ge ? diff[RAMP_W-1:0] : rem_in[RAMP_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
            ctrl_reg.mode  <= LVL_ZERO;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            div_reg <= div_in;
            quo_reg <= {quo_in[QW-2:0], ge};
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign quo_out  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ssrd_sine_rom.sv =====
// Quarter-sine ROM, floor(255*sin) over one quadrant, with registered read.
`default_nettype none

module ssrd_sine_rom
    import ssrd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [FRACTION_BITS-1:0] addr,
    output      logic [7:0]               data
);

    localparam int DEPTH = 1 << FRACTION_BITS;

    typedef logic [7:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k < DEPTH; k++) begin
            r[k] = quarter_sine(32'(k), FRACTION_BITS);
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [7:0] data_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scheduled_sine_ramp_dimmer.sv =====
// Top level of the scheduled sine-ramp LED dimmer: schedule decode, divider cells, sine ROM.
//
// Channel   Dir  Bits  Contents
// s_*       in   24    second_of_day [16:0], weekday [19:17], zero fill [23:20]
// m_*       out  8     brightness [7:0]
// APB       in   5/32  schedule and ramp registers at byte addresses 0,4,8,12,16
//
// One request enters per cycle and one brightness leaves per cycle while m_tready stays
// high; from acceptance to m_tvalid a request passes the input register, the row of
// FRACTION_BITS + 1 division cells (one quotient bit each), the ROM register and the
// output register. aresetn is synchronous; it clears all valid bits and loads the
// register reset schedule. A two-entry output buffer takes a result while the previous
// one waits; the whole pipe holds only once both entries are full.
`default_nettype none

module scheduled_sine_ramp_dimmer
    import ssrd_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request channel
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [23:0]       s_tdata,   // [16:0] second_of_day, [19:17] weekday
    // result channel
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [7:0]        m_tdata,   // [7:0] brightness
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    localparam int QW = FRACTION_BITS + 1;

    cfg_t cfg;

    ssrd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipe enable: advance everything unless the output skid entry is occupied.
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------- input stage
    // Pick the schedule for the weekday and convert minutes to seconds (x*64 - x*4).
    logic [2:0]        in_day;
    logic [10:0]       on_min;
    logic [10:0]       off_min;
    logic [TIME_W-1:0] on_sec_next;
    logic [TIME_W-1:0] off_sec_next;
    logic [RAMP_W-1:0] ramp_sec_next;

    logic              in_valid_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] on_sec_reg;
    logic [TIME_W-1:0] off_sec_reg;
    logic [RAMP_W-1:0] ramp_sec_reg;

    assign in_day  = s_tdata[19:17];
    assign on_min  = (in_day == DAY_SUN || in_day == DAY_SAT) ? cfg.on_we : cfg.on_wd;
    assign off_min = (in_day == DAY_FRI || in_day == DAY_SAT) ? cfg.off_we : cfg.off_wd;

    assign on_sec_next   = {on_min, 6'd0} - {4'd0, on_min, 2'd0};
    assign off_sec_next  = {off_min, 6'd0} - {4'd0, off_min, 2'd0};
    assign ramp_sec_next = {cfg.ramp, 6'd0} - {4'd0, cfg.ramp, 2'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg        <= s_tdata[TIME_W-1:0];
            on_sec_reg   <= on_sec_next;
            off_sec_reg  <= off_sec_next;
            ramp_sec_reg <= ramp_sec_next;
        end
    end

    // ---------------------------------------------------------------- classify
    // Off at or before on time and from off time on; the rising ramp wins where
    // both ramps overlap. A zero ramp length can never reach either ramp.
    logic [TIME_W:0]   on_plus_ramp;
    logic [TIME_W:0]   t_plus_ramp;
    logic              is_off;
    logic              in_rise;
    logic              in_fall;
    logic [TIME_W-1:0] elapsed;
    cell_ctrl_t        cls_ctrl;

    assign on_plus_ramp = {1'b0, on_sec_reg} + {2'd0, ramp_sec_reg};
    assign t_plus_ramp  = {1'b0, t_reg} + {2'd0, ramp_sec_reg};
    assign is_off       = (t_reg <= on_sec_reg) || (t_reg >= off_sec_reg);
    assign in_rise      = {1'b0, t_reg} <= on_plus_ramp;
    assign in_fall      = t_plus_ramp >= {1'b0, off_sec_reg};
    assign elapsed      = in_rise ? (t_reg - on_sec_reg) : (off_sec_reg - t_reg);

    always_comb begin
        cls_ctrl.valid = in_valid_reg;
        priority if (is_off) begin
            cls_ctrl.mode = LVL_ZERO;
        end else if (in_rise || in_fall) begin
            cls_ctrl.mode = LVL_RAMP;
        end else begin
            cls_ctrl.mode = LVL_FULL;
        end
    end

    // ---------------------------------------------------------------- divider row
    // k = floor(elapsed * 2^FRACTION_BITS / ramp): elapsed never exceeds the ramp,
    // so QW restoring steps give the whole quotient, MSB first.
    cell_ctrl_t        ctrl_chain [QW+1];
    logic [RAMP_W-1:0] div_chain  [QW+1];
    logic [QW-1:0]     quo_chain  [QW+1];
    logic [RAMP_W-1:0] rem_chain  [QW];

    assign ctrl_chain[0] = cls_ctrl;
    assign div_chain[0]  = ramp_sec_reg;
    assign quo_chain[0]  = '0;

    for (genvar i = 0; i < QW; i++) begin : g_cell
        logic [RAMP_W:0] rem_in;
        if (i == 0) begin : g_first
            assign rem_in = elapsed;
        end else begin : g_next
            assign rem_in = {rem_chain[i-1], 1'b0};
        end

        ssrd_cell #(
            .QW (QW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl_chain[i]),
            .rem_in   (rem_in),
            .div_in   (div_chain[i]),
            .quo_in   (quo_chain[i]),
            .ctrl_out (ctrl_chain[i+1]),
            .rem_out  (rem_chain[i]),
            .div_out  (div_chain[i+1]),
            .quo_out  (quo_chain[i+1])
        );
    end

    // ---------------------------------------------------------------- sine lookup
    // A quotient of exactly 2^FRACTION_BITS means the ramp end: full brightness.
    cell_ctrl_t rom_ctrl_reg;
    logic       rom_full_reg;
    logic [7:0] rom_data;

    ssrd_sine_rom #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_rom (
        .aclk (aclk),
        .en   (en),
        .addr (quo_chain[QW][FRACTION_BITS-1:0]),
        .data (rom_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_ctrl_reg.valid <= 1'b0;
            rom_ctrl_reg.mode  <= LVL_ZERO;
        end else if (en) begin
            rom_ctrl_reg <= ctrl_chain[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rom_full_reg <= quo_chain[QW][FRACTION_BITS];
        end
    end

    logic [7:0] level;

    always_comb begin
        unique case (rom_ctrl_reg.mode)
            LVL_ZERO: level = LEVEL_OFF;
            LVL_FULL: level = LEVEL_FULL;
            LVL_RAMP: level = rom_full_reg ? LEVEL_FULL : rom_data;
            default:  level = LEVEL_OFF;
        endcase
    end

    // ---------------------------------------------------------------- output buffer
    // Main entry drives the port; the skid entry catches a result that arrives while
    // the main one is stalled, and holds the pipe until it drains.
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [7:0] skid_data_reg;
    logic       take;
    logic       incoming;

    assign take     = out_valid_reg && m_tready;
    assign incoming = en && rom_ctrl_reg.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (incoming) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= level;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= level;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------- checks
    // The skid entry is only ever filled behind a waiting main entry.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while main entry is empty");

    // A ramp only starts with a nonzero divisor and a nonzero phase no larger than it.
    a_ramp_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (cls_ctrl.valid && cls_ctrl.mode == LVL_RAMP) |->
            (ramp_sec_reg != '0 && elapsed != '0 && {1'b0, elapsed} <= {2'b0, ramp_sec_reg}))
        else $error("ramp entered with bad divisor or phase");

    // The last cell leaves a proper remainder for every ramp request.
    a_final_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_chain[QW].valid && ctrl_chain[QW].mode == LVL_RAMP) |->
            rem_chain[QW-1] < div_chain[QW])
        else $error("division remainder not below divisor");

    // A full-scale quotient carries no fraction bits.
    a_quotient_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_chain[QW].valid && ctrl_chain[QW].mode == LVL_RAMP &&
            quo_chain[QW][FRACTION_BITS]) |-> quo_chain[QW][FRACTION_BITS-1:0] == '0)
        else $error("ramp phase above full scale");

endmodule

`default_nettype wire
